[rtl/rtdt_pkg.sv]
// Shared types, status codes and calendar helpers for the RTC reading decoder.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps

package rtdt_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_HALT = 2'd1;
  localparam logic [1:0] ST_H12  = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  localparam logic [10:0] MIN_PER_DAY = 11'd1440;
  localparam logic [31:0] SEC_PER_DAY = 32'd86400;

  typedef struct packed {
    logic [7:0]  seconds_reg;
    logic [7:0]  minutes_reg;
    logic [7:0]  hours_reg;
    logic [7:0]  date_reg;
    logic [7:0]  month_reg;
    logic [7:0]  weekday_reg;
    logic [7:0]  year_reg;
    logic [10:0] query_minute;
  } raw_t;

  typedef struct packed {
    logic [6:0] year;
    logic [2:0] wday;
    logic [3:0] mon;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] min;
    logic [5:0] sec;
  } held_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        ok;
    held_t       held;
    logic [10:0] qmin;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // high nibble times ten plus low nibble, no digit check
  function automatic logic [7:0] bcd8(input logic [7:0] b);
    logic [7:0] hi;
    hi = {4'd0, b[7:4]};
    return 8'((hi << 3) + (hi << 1) + {4'd0, b[3:0]});
  endfunction

  function automatic logic [4:0] days_in_month(input logic leap, input logic [7:0] mon);
    logic [4:0] d;
    unique case (mon)
      8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: d = 5'd31;
      8'd4, 8'd6, 8'd9, 8'd11:                    d = 5'd30;
      8'd2:                                       d = leap ? 5'd29 : 5'd28;
      default:                                    d = 5'd0;
    endcase
    return d;
  endfunction

  function automatic logic [8:0] month_start(input logic [3:0] mon);
    logic [8:0] s;
    unique case (mon)
      4'd2:    s = 9'd31;
      4'd3:    s = 9'd59;
      4'd4:    s = 9'd90;
      4'd5:    s = 9'd120;
      4'd6:    s = 9'd151;
      4'd7:    s = 9'd181;
      4'd8:    s = 9'd212;
      4'd9:    s = 9'd243;
      4'd10:   s = 9'd273;
      4'd11:   s = 9'd304;
      4'd12:   s = 9'd334;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

[rtl/rtc_time_decode_timestamp.sv]
// Decodes one burst read of a BCD real-time clock per word into status, the held
// date/time, days and seconds since 2000-01-01 and the next timestamp at a query minute.
// The block takes one word per clock cycle for as long as the result side keeps
// taking words; an accepted reading passes through the queue, then the day count, the
// seconds multiply and the output register. The queue (QUEUE_DEPTH words) lets input
// keep flowing while a result waits.
// A halted clock or twelve-hour mode is rejected before the calendar check; a rejected
// reading keeps the held fields and gives day number 65535 and zero timestamps.
`timescale 1ns / 1ps

module rtc_time_decode_timestamp #(
  parameter int QUEUE_DEPTH = rtdt_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // seconds_reg[7:0], minutes_reg[15:8], hours_reg[23:16], date_reg[31:24],
  // month_reg[39:32], weekday_reg[47:40], year_reg[55:48], query_minute[66:56]
  input  logic [71:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // held_second[5:0], held_minute[11:6], held_hour[16:12], held_day[21:17],
  // held_month[25:22], held_weekday[28:26], held_year_offset[35:29],
  // day_number[51:36], epoch_seconds[83:52], next_occurrence[115:84]
  output logic [119:0] out_tdata,
  // status[1:0], time_valid[2]
  output logic [2:0]   out_tuser
);

  rtdt_pkg::raw_t    raw;
  rtdt_pkg::entry_t  fe_entry;
  rtdt_pkg::entry_t  q_entry;
  rtdt_pkg::entry_t  res_entry;
  rtdt_pkg::q_stat_t q_stat;
  logic        push;
  logic        pop;
  logic [15:0] res_day_number;
  logic [31:0] res_epoch;
  logic [31:0] res_next;

  assign raw.seconds_reg  = in_tdata[7:0];
  assign raw.minutes_reg  = in_tdata[15:8];
  assign raw.hours_reg    = in_tdata[23:16];
  assign raw.date_reg     = in_tdata[31:24];
  assign raw.month_reg    = in_tdata[39:32];
  assign raw.weekday_reg  = in_tdata[47:40];
  assign raw.year_reg     = in_tdata[55:48];
  assign raw.query_minute = in_tdata[66:56];

  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && in_tready;

  rtdt_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .raw   (raw),
    .entry (fe_entry)
  );

  rtdt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (fe_entry),
    .pop      (pop),
    .rd_entry (q_entry),
    .stat     (q_stat)
  );

  rtdt_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_stat.empty),
    .q_entry        (q_entry),
    .pop            (pop),
    .out_ready      (out_tready),
    .out_valid      (out_tvalid),
    .res_entry      (res_entry),
    .res_day_number (res_day_number),
    .res_epoch      (res_epoch),
    .res_next       (res_next)
  );

  assign out_tuser = {res_entry.ok, res_entry.status};
  assign out_tdata = {4'd0, res_next, res_epoch, res_day_number,
                      res_entry.held.year, res_entry.held.wday, res_entry.held.mon,
                      res_entry.held.day, res_entry.held.hour, res_entry.held.min,
                      res_entry.held.sec};

`ifndef ASSERT_OFF
  a_valid_means_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[1:0] == rtdt_pkg::ST_OK)
    else $error("accepted reading reported with a failure status");

  a_reject_blanks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[2] |->
      out_tdata[51:36] == 16'hFFFF && out_tdata[83:52] == 32'd0 &&
      out_tdata[115:84] == 32'd0)
    else $error("rejected reading carries timestamps");

  a_ok_fields_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |->
      out_tdata[16:12] <= 5'd23 && out_tdata[21:17] != 5'd0 &&
      out_tdata[25:22] != 4'd0 && out_tdata[25:22] <= 4'd12 &&
      out_tdata[35:29] >= 7'd20 && out_tdata[35:29] <= 7'd99)
    else $error("accepted reading holds fields outside the calendar");

  a_queue_not_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty at once");
`endif

endmodule

[rtl/rtdt_front.sv]
// Front end: classifies a raw reading, checks the calendar and keeps the held date/time.
// Depends on rtdt_pkg.
`timescale 1ns / 1ps

module rtdt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rtdt_pkg::raw_t    raw,
  output rtdt_pkg::entry_t  entry
);

  rtdt_pkg::held_t held_r;
  rtdt_pkg::held_t held_nxt;
  rtdt_pkg::held_t dec;
  logic [7:0] s, mi, h, d, mo, w, y;
  logic       leap;
  logic       cal_ok;
  logic       ok;
  logic [1:0] status;

  always_comb begin
    s  = rtdt_pkg::bcd8(raw.seconds_reg & 8'h7F);
    mi = rtdt_pkg::bcd8(raw.minutes_reg & 8'h7F);
    h  = rtdt_pkg::bcd8(raw.hours_reg & 8'h3F);
    d  = rtdt_pkg::bcd8(raw.date_reg & 8'h3F);
    mo = rtdt_pkg::bcd8(raw.month_reg & 8'h1F);
    w  = rtdt_pkg::bcd8(raw.weekday_reg & 8'h07);
    y  = rtdt_pkg::bcd8(raw.year_reg);
    // only years 2020..2099 pass, where every fourth year is leap
    leap = (y[1:0] == 2'd0);
    cal_ok = (y >= 8'd20) && (y <= 8'd99) && (mo >= 8'd1) && (mo <= 8'd12) &&
             (d >= 8'd1) && (d <= {3'd0, rtdt_pkg::days_in_month(leap, mo)}) &&
             (h <= 8'd23) && (mi <= 8'd59) && (s <= 8'd59) &&
             (w >= 8'd1) && (w <= 8'd7);

    priority if (raw.seconds_reg[7]) begin
      status = rtdt_pkg::ST_HALT;
      ok     = 1'b0;
    end else if (raw.hours_reg[7]) begin
      status = rtdt_pkg::ST_H12;
      ok     = 1'b0;
    end else if (cal_ok) begin
      status = rtdt_pkg::ST_OK;
      ok     = 1'b1;
    end else begin
      status = rtdt_pkg::ST_BAD;
      ok     = 1'b0;
    end

    dec.sec  = s[5:0];
    dec.min  = mi[5:0];
    dec.hour = h[4:0];
    dec.day  = d[4:0];
    dec.mon  = mo[3:0];
    dec.wday = w[2:0];
    dec.year = y[6:0];

    held_nxt = (push && ok) ? dec : held_r;

    entry.status = status;
    entry.ok     = ok;
    entry.held   = ok ? dec : held_r;
    entry.qmin   = raw.query_minute;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else begin
      held_r <= held_nxt;
    end
  end

endmodule

[rtl/rtdt_queue.sv]
// Short FIFO of classified words between the front end and the timestamp pipeline.
// Depends on rtdt_pkg.
`timescale 1ns / 1ps

module rtdt_queue #(
  parameter int DEPTH = rtdt_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rtdt_pkg::entry_t  wr_entry,
  input  logic              pop,
  output rtdt_pkg::entry_t  rd_entry,
  output rtdt_pkg::q_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  rtdt_pkg::entry_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  always_comb begin
    stat.full  = (cnt_r == FULL_CNT);
    stat.empty = (cnt_r == '0);
    do_push = push && !stat.full;
    do_pop  = pop && !stat.empty;
    wr_ptr_nxt = do_push ? ((wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ((rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
    rd_entry = slot_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[rtl/rtdt_back.sv]
// Back end: day count, seconds since 2000 and next occurrence in three registered steps.
// Depends on rtdt_pkg; ends in the output register of the result channel.
`timescale 1ns / 1ps

module rtdt_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  rtdt_pkg::entry_t  q_entry,
  output logic              pop,
  input  logic              out_ready,
  output logic              out_valid,
  output rtdt_pkg::entry_t  res_entry,
  output logic [15:0]       res_day_number,
  output logic [31:0]       res_epoch,
  output logic [31:0]       res_next
);

  logic en;

  // step 1: day number
  logic             s1_valid_r, s1_valid_nxt;
  rtdt_pkg::entry_t s1_entry_r;
  logic [15:0]      s1_dnum_r, s1_dnum_nxt;

  // step 2: day base in seconds, time of day, query seconds
  logic             s2_valid_r, s2_valid_nxt;
  rtdt_pkg::entry_t s2_entry_r;
  logic [15:0]      s2_dnum_r;
  logic [31:0]      s2_base_r, s2_base_nxt;
  logic [16:0]      s2_tod_r, s2_tod_nxt;
  logic [16:0]      s2_qsec_r, s2_qsec_nxt;
  logic             s2_qv_r, s2_qv_nxt;

  // step 3: output register
  logic             o_valid_r, o_valid_nxt;
  rtdt_pkg::entry_t o_entry_r;
  logic [15:0]      o_dnum_r, o_dnum_nxt;
  logic [31:0]      o_epoch_r, o_epoch_nxt;
  logic [31:0]      o_next_r, o_next_nxt;

  logic [6:0]  yr;
  logic [31:0] esec, nsec;

  always_comb begin
    en  = !o_valid_r || out_ready;
    pop = en && !q_empty;

    yr = q_entry.held.year;
    s1_valid_nxt = en ? pop : s1_valid_r;
    s1_dnum_nxt  = 16'(16'(yr) * 16'd365) + 16'((8'(yr) + 8'd3) >> 2)
                 + 16'(rtdt_pkg::month_start(q_entry.held.mon))
                 + 16'((q_entry.held.mon > 4'd2) && (yr[1:0] == 2'd0))
                 + 16'(q_entry.held.day) - 16'd1;

    s2_valid_nxt = en ? s1_valid_r : s2_valid_r;
    s2_base_nxt  = 32'(s1_dnum_r) * rtdt_pkg::SEC_PER_DAY;
    s2_tod_nxt   = 17'(17'(s1_entry_r.held.hour) * 17'd3600)
                 + 17'(17'(s1_entry_r.held.min) * 17'd60)
                 + 17'(s1_entry_r.held.sec);
    s2_qsec_nxt  = 17'(17'(s1_entry_r.qmin) * 17'd60);
    s2_qv_nxt    = (s1_entry_r.qmin < rtdt_pkg::MIN_PER_DAY);

    // next <= now exactly when query seconds <= time of day: roll to tomorrow
    esec = s2_base_r + 32'(s2_tod_r);
    nsec = s2_base_r + 32'(s2_qsec_r)
         + ((s2_qsec_r <= s2_tod_r) ? rtdt_pkg::SEC_PER_DAY : 32'd0);

    o_valid_nxt = en ? s2_valid_r : o_valid_r;
    o_dnum_nxt  = s2_entry_r.ok ? s2_dnum_r : 16'hFFFF;
    o_epoch_nxt = s2_entry_r.ok ? esec : 32'd0;
    o_next_nxt  = (s2_entry_r.ok && s2_qv_r) ? nsec : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      o_valid_r  <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_entry_r <= q_entry;
      s1_dnum_r  <= s1_dnum_nxt;
      s2_entry_r <= s1_entry_r;
      s2_dnum_r  <= s1_dnum_r;
      s2_base_r  <= s2_base_nxt;
      s2_tod_r   <= s2_tod_nxt;
      s2_qsec_r  <= s2_qsec_nxt;
      s2_qv_r    <= s2_qv_nxt;
      o_entry_r  <= s2_entry_r;
      o_dnum_r   <= o_dnum_nxt;
      o_epoch_r  <= o_epoch_nxt;
      o_next_r   <= o_next_nxt;
    end
  end

  assign out_valid      = o_valid_r;
  assign res_entry      = o_entry_r;
  assign res_day_number = o_dnum_r;
  assign res_epoch      = o_epoch_r;
  assign res_next       = o_next_r;

endmodule

[test/rtc_time_decode_timestamp_tb.sv]
// Self-checking bench for rtc_time_decode_timestamp: directed readings, then random bursts
// decoded by a local calendar model and compared field by field. Depends on rtdt_pkg.
`timescale 1ns / 1ps

module rtc_time_decode_timestamp_tb;

  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASE_ITEMS  = 560;
  localparam int DRAIN_CYCLES = 16;

  localparam logic [1:0]  ST_OK       = rtdt_pkg::ST_OK;
  localparam logic [1:0]  ST_HALT     = rtdt_pkg::ST_HALT;
  localparam logic [1:0]  ST_H12      = rtdt_pkg::ST_H12;
  localparam logic [1:0]  ST_BAD      = rtdt_pkg::ST_BAD;
  localparam logic [10:0] MIN_PER_DAY = rtdt_pkg::MIN_PER_DAY;
  localparam logic [31:0] SEC_PER_DAY = rtdt_pkg::SEC_PER_DAY;

  // last field in the lowest bits, so the packed struct is the tdata layout
  typedef struct packed {
    logic [10:0] qmin;
    logic [7:0]  year_r;
    logic [7:0]  wday_r;
    logic [7:0]  mon_r;
    logic [7:0]  date_r;
    logic [7:0]  hour_r;
    logic [7:0]  min_r;
    logic [7:0]  sec_r;
  } reading_t;

  // matches {out_tdata[115:0], out_tuser}
  typedef struct packed {
    logic [31:0] next_occ;
    logic [31:0] esec;
    logic [15:0] dnum;
    logic [6:0]  year;
    logic [2:0]  wday;
    logic [3:0]  mon;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  min;
    logic [5:0]  sec;
    logic        valid;
    logic [1:0]  status;
  } res_t;

  typedef struct {
    reading_t rd;
    bit       typed;
    logic [1:0] st;
  } vec_t;

  localparam int unsigned MONTH_FIRST [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                               304, 334};
  localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [71:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;
  logic [2:0]   out_tuser;

  res_t pending_results[$];
  vec_t dir_vecs[$];
  int   err_cnt = 0;
  int   cycles = 0;
  int   tx_idle = 31;
  int   rx_idle = 86;

  // held date and time of the last accepted reading
  logic [5:0] held_sec = '0;
  logic [5:0] held_min = '0;
  logic [4:0] held_hour = '0;
  logic [4:0] held_day = '0;
  logic [3:0] held_mon = '0;
  logic [2:0] held_wday = '0;
  logic [6:0] held_year = '0;

  string field_name [12] = '{"status", "time_valid", "held_second", "held_minute",
                             "held_hour", "held_day", "held_month", "held_weekday",
                             "held_year_offset", "day_number", "epoch_seconds",
                             "next_occurrence"};

  rtc_time_decode_timestamp dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  function automatic bit is_leap(int unsigned yoff);
    int unsigned y;
    y = 2000 + yoff;
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(int unsigned yoff, int unsigned mo);
    if (mo < 1 || mo > 12) return 0;
    if (mo == 2 && is_leap(yoff)) return 29;
    return MONTH_LEN[mo - 1];
  endfunction

  function automatic int unsigned bcd_val(logic [7:0] b);
    return int'(b[7:4]) * 10 + int'(b[3:0]);
  endfunction

  // sometimes encode with a low digit above nine, which decodes to the same value
  function automatic logic [7:0] bcd_enc(int unsigned v);
    if (v >= 10 && v % 10 < 6 && $urandom_range(3) == 0)
      return 8'((((v / 10) - 1) << 4) | (v % 10 + 10));
    return 8'(((v / 10) << 4) | (v % 10));
  endfunction

  function automatic logic [31:0] field_of(res_t r, int i);
    case (i)
      0:       return 32'(r.status);
      1:       return 32'(r.valid);
      2:       return 32'(r.sec);
      3:       return 32'(r.min);
      4:       return 32'(r.hour);
      5:       return 32'(r.day);
      6:       return 32'(r.mon);
      7:       return 32'(r.wday);
      8:       return 32'(r.year);
      9:       return 32'(r.dnum);
      10:      return r.esec;
      default: return r.next_occ;
    endcase
  endfunction

  // decode one reading, update the held date and time, build the result word
  function automatic res_t decode_reading(reading_t rd);
    res_t r;
    int unsigned s, mi, h, d, mo, w, y, days, dn, nxt;
    bit ok;
    r = '0;
    r.status = ST_OK;
    r.dnum = 16'hFFFF;
    ok = 1'b0;
    if (rd.sec_r[7]) begin
      r.status = ST_HALT;
    end else if (rd.hour_r[7]) begin
      r.status = ST_H12;
    end else begin
      s  = bcd_val(rd.sec_r & 8'h7F);
      mi = bcd_val(rd.min_r & 8'h7F);
      h  = bcd_val(rd.hour_r & 8'h3F);
      d  = bcd_val(rd.date_r & 8'h3F);
      mo = bcd_val(rd.mon_r & 8'h1F);
      w  = bcd_val(rd.wday_r & 8'h07);
      y  = bcd_val(rd.year_r);
      ok = (y >= 20 && y <= 99) && (mo >= 1 && mo <= 12) &&
           (d >= 1 && d <= month_days(y, mo)) && (h <= 23 && mi <= 59 && s <= 59) &&
           (w >= 1 && w <= 7);
      if (ok) begin
        held_sec  = 6'(s);
        held_min  = 6'(mi);
        held_hour = 5'(h);
        held_day  = 5'(d);
        held_mon  = 4'(mo);
        held_wday = 3'(w);
        held_year = 7'(y);
      end else begin
        r.status = ST_BAD;
      end
    end
    r.valid = ok;
    r.sec   = held_sec;
    r.min   = held_min;
    r.hour  = held_hour;
    r.day   = held_day;
    r.mon   = held_mon;
    r.wday  = held_wday;
    r.year  = held_year;
    if (ok) begin
      y = held_year;
      days = 365 * y + (y + 3) / 4 + MONTH_FIRST[held_mon - 1] + int'(held_day) - 1;
      if (held_mon > 2 && is_leap(y)) days = days + 1;
      dn = days & 32'hFFFF;
      r.dnum = 16'(dn);
      r.esec = dn * SEC_PER_DAY + held_hour * 3600 + held_min * 60 + held_sec;
      if (rd.qmin < MIN_PER_DAY) begin
        nxt = dn * SEC_PER_DAY + rd.qmin * 60;
        // today's occurrence already passed: take tomorrow's
        if (nxt <= r.esec) nxt = nxt + SEC_PER_DAY;
        r.next_occ = nxt;
      end
    end
    return r;
  endfunction

  function automatic reading_t make_reading();
    reading_t rd;
    logic [95:0] noise;
    int unsigned kind, y, mo, d, h, mi, s, w, sel, now_min;
    kind = $urandom_range(99);
    y  = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 20 : 99) : $urandom_range(99, 20);
    mo = $urandom_range(12, 1);
    d  = ($urandom_range(3) == 0) ? month_days(y, mo) : $urandom_range(month_days(y, mo), 1);
    h  = $urandom_range(23);
    mi = $urandom_range(59);
    s  = $urandom_range(59);
    w  = $urandom_range(7, 1);
    rd.sec_r  = bcd_enc(s);
    rd.min_r  = bcd_enc(mi) | {1'($urandom), 7'd0};
    rd.hour_r = bcd_enc(h) | {1'b0, 1'($urandom), 6'd0};
    rd.date_r = bcd_enc(d) | {2'($urandom), 6'd0};
    rd.mon_r  = bcd_enc(mo) | {3'($urandom), 5'd0};
    rd.wday_r = 8'(w) | {5'($urandom), 3'd0};
    rd.year_r = bcd_enc(y);
    now_min = h * 60 + mi;
    sel = $urandom_range(99);
    if (sel < 50) rd.qmin = 11'((now_min + 1440 + $urandom_range(2) - 1) % 1440);
    else if (sel < 85) rd.qmin = 11'($urandom_range(1439));
    else rd.qmin = 11'($urandom_range(2047));
    if (kind >= 70 && kind < 80) begin
      // break one field, keep the mode bits clear
      case ($urandom_range(6))
        0:       rd.sec_r  = 8'($urandom_range(127));
        1:       rd.min_r  = 8'($urandom);
        2:       rd.hour_r = 8'($urandom_range(127));
        3:       rd.date_r = 8'($urandom);
        4:       rd.mon_r  = 8'($urandom);
        5:       rd.wday_r = 8'($urandom);
        default: rd.year_r = 8'($urandom);
      endcase
    end else if (kind >= 80 && kind < 84) begin
      rd.sec_r[7]  = 1'b1;
      rd.hour_r[7] = 1'($urandom);
    end else if (kind >= 84 && kind < 88) begin
      rd.hour_r[7] = 1'b1;
    end else if (kind >= 88) begin
      noise = {$urandom, $urandom, $urandom};
      rd = noise[66:0];
    end
    return rd;
  endfunction

  task automatic add_vec(logic [7:0] s, logic [7:0] m, logic [7:0] h, logic [7:0] d,
                         logic [7:0] mo, logic [7:0] w, logic [7:0] y, logic [10:0] q,
                         bit typed, logic [1:0] st);
    vec_t v;
    v.rd = '{qmin: q, year_r: y, wday_r: w, mon_r: mo, date_r: d, hour_r: h, min_r: m,
             sec_r: s};
    v.typed = typed;
    v.st = st;
    dir_vecs.push_back(v);
  endtask

  // returns at the edge where the word is taken
  task automatic send_reading(reading_t rd);
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, rd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("rtc_time_decode_timestamp: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin : result_check
    res_t act, want;
    if (rst_n && out_tvalid && out_tready) begin
      act = res_t'({out_tdata[115:0], out_tuser});
      if (pending_results.size() == 0) begin
        $display("%0t unexpected word: tuser=%h tdata=%h", $time, out_tuser, out_tdata);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        for (int i = 0; i < 12; i++) begin
          if (field_of(want, i) !== field_of(act, i)) begin
            $display("%0t %s: expected %0d, got %0d", $time, field_name[i],
                     field_of(want, i), field_of(act, i));
            err_cnt++;
          end
        end
      end
    end
    out_tready <= rst_n && ($urandom_range(99) >= rx_idle);
  end

  initial begin : stimulus
    res_t want;
    reading_t rd;
    // rejected readings before anything is held: held fields stay zero
    add_vec(8'h80, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h20, 11'd0, 1, ST_HALT);
    add_vec(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 11'd2047, 1, ST_HALT);
    add_vec(8'h00, 8'h00, 8'h92, 8'h01, 8'h01, 8'h01, 8'h20, 11'd0, 1, ST_H12);
    add_vec(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 11'd0, 1, ST_BAD);
    add_vec(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h19, 11'd0, 1, ST_BAD);
    add_vec(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'hA0, 11'd0, 1, ST_BAD);
    add_vec(8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h01, 8'h20, 11'd0, 1, ST_BAD);
    add_vec(8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h20, 11'd0, 1, ST_BAD);
    add_vec(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h20, 11'd0, 1, ST_BAD);
    add_vec(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h01, 8'h21, 11'd0, 1, ST_BAD);
    add_vec(8'h00, 8'h00, 8'h24, 8'h01, 8'h01, 8'h01, 8'h20, 11'd0, 1, ST_BAD);
    add_vec(8'h00, 8'h60, 8'h00, 8'h01, 8'h01, 8'h01, 8'h20, 11'd0, 1, ST_BAD);
    add_vec(8'h60, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h20, 11'd0, 1, ST_BAD);
    add_vec(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 8'h20, 11'd0, 1, ST_BAD);
    add_vec(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h08, 8'h20, 11'd0, 1, ST_BAD);
    // first and last accepted instants, query at or before now rolls to tomorrow
    add_vec(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h20, 11'd0, 0, ST_OK);
    add_vec(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h07, 8'h99, 11'd1439, 0, ST_OK);
    add_vec(8'h00, 8'h30, 8'h12, 8'h29, 8'h02, 8'h04, 8'h24, 11'd750, 0, ST_OK);
    add_vec(8'h00, 8'h30, 8'h12, 8'h29, 8'h02, 8'h04, 8'h24, 11'd751, 0, ST_OK);
    add_vec(8'h00, 8'h30, 8'h12, 8'h29, 8'h02, 8'h04, 8'h24, 11'd1440, 0, ST_OK);
    add_vec(8'h00, 8'h30, 8'h12, 8'h29, 8'h02, 8'h04, 8'h24, 11'd2047, 0, ST_OK);
    // digits above nine that still decode into range
    add_vec(8'h1A, 8'h4F, 8'h0D, 8'h0F, 8'h0A, 8'h05, 8'h2F, 11'd100, 0, ST_OK);
    // rejected after an accepted reading: held fields kept
    add_vec(8'hA0, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h20, 11'd5, 0, ST_OK);
    // unused high bits set everywhere they are masked off
    add_vec(8'h59, 8'hD9, 8'h63, 8'hF1, 8'hE8, 8'hFF, 8'h45, 11'd2000, 0, ST_OK);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_vecs[i]) begin
      send_reading(dir_vecs[i].rd);
      want = decode_reading(dir_vecs[i].rd);
      if (dir_vecs[i].typed) begin
        want = '0;
        want.status = dir_vecs[i].st;
        want.dnum = 16'hFFFF;
      end
      pending_results.push_back(want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      // hold off the sender until every result is out
      wait_drained();
      case (phase)
        0: begin tx_idle = 31; rx_idle = 86; end
        1: begin tx_idle = 86; rx_idle = 31; end
        default: begin tx_idle = 0; rx_idle = 0; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        rd = make_reading();
        send_reading(rd);
        pending_results.push_back(decode_reading(rd));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("rtc_time_decode_timestamp: match");
    end else begin
      $display("rtc_time_decode_timestamp: mismatch");
    end
    $finish;
  end

endmodule
